/* rtl/indexed_list_store_macros.svh */
// ----------------------------------------------------------------------------
// Indexed list store assertion macros
// Shared concurrent assertion forms for the list store checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_MACROS_SVH
`define INDEXED_LIST_STORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ILS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ils_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store package
// Command codes, field widths and the control and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package ils_pkg;

  // Field widths of one transaction on each channel.
  localparam int CMD_W     = 3;
  localparam int POS_W     = 8;
  localparam int DATA_W    = 32;
  localparam int CNT_OUT_W = 9;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_GET  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_HEAD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TAIL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_AT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DEL  = 3'd4;

  // Read value returned for a get at an index outside the list.
  localparam logic [DATA_W-1:0] RD_INVALID = '1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic decide;
    logic ptr_load;
    logic shift_rd;
    logic shift_wr;
    logic ptr_step;
    logic commit;
    logic load_out;
  } ils_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_shift;
    logic need_commit;
    logic shift_last;
    logic out_free;
  } ils_stat_t;

endpackage

/* rtl/ils_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store controller
// Sequences one command at a time: decide, shift the store entry by entry and
// commit the count change as needed; hand the result to the output register.
// ----------------------------------------------------------------------------
module ils_ctrl
  import ils_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ils_stat_t stat,
  output ils_ctl_t  ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SHRD   = 3'd2;
  localparam logic [2:0] S_SHWR   = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_RESULT = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // The input side is open only while no command is in progress.
  assign in_stall = (state_r != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch_in = 1'b1;
          state_nxt    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ctl.decide = 1'b1;
        if (stat.need_shift) begin
          ctl.ptr_load = 1'b1;
          state_nxt    = S_SHRD;
        end else if (stat.need_commit) begin
          state_nxt = S_COMMIT;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_SHRD: begin
        ctl.shift_rd = 1'b1;
        state_nxt    = S_SHWR;
      end
      S_SHWR: begin
        ctl.shift_wr = 1'b1;
        if (stat.shift_last) begin
          state_nxt = S_COMMIT;
        end else begin
          ctl.ptr_step = 1'b1;
          state_nxt    = S_SHRD;
        end
      end
      S_COMMIT: begin
        ctl.commit = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/ils_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store datapath
// Holds the entry memory, the entry count, the shift pointer, the latched
// command and the output register.
// ----------------------------------------------------------------------------
module ils_datapath
  import ils_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [CMD_W-1:0]            in_cmd,
  input  logic [POS_W-1:0]            in_position,
  input  logic signed [DATA_W-1:0]    in_value,
  input  logic                        out_stall,
  input  ils_ctl_t                    ctl,
  output ils_stat_t                   stat,
  output logic                        out_valid,
  output logic signed [DATA_W-1:0]    out_read_value,
  output logic                        out_accepted,
  output logic [CNT_OUT_W-1:0]        out_entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

  // Latched command.
  logic [CMD_W-1:0]  cmd_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;

  // List state and working registers.
  logic [DATA_W-1:0] mem [CAPACITY];
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [AW-1:0]     ptr_r;
  logic [AW-1:0]     ptr_nxt;
  logic [DATA_W-1:0] rd_r;
  logic              ok_r;

  // Output register.
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic signed [DATA_W-1:0] out_read_value_r;
  logic                     out_accepted_r;
  logic [CNT_OUT_W-1:0]     out_entry_count_r;

  // Decode signals.
  logic [EW-1:0] pos_e;
  logic [EW-1:0] cnt_e;
  logic [EW-1:0] ptr_e;
  logic [EW-1:0] ins_idx_e;
  logic          is_get;
  logic          is_ins;
  logic          is_del;
  logic          full;
  logic          get_ok;
  logic          ins_ok;
  logic          del_ok;
  logic          ins_shift;
  logic          del_shift;
  logic [AW-1:0] pos_addr;
  logic [AW-1:0] ins_addr;
  logic [AW-1:0] rd_addr;
  logic          rd_en;
  logic [AW-1:0] wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic          wr_en;

  // Command decode and range checks against the current count.
  always_comb begin
    pos_e  = EW'(pos_r);
    cnt_e  = EW'(count_r);
    ptr_e  = EW'(ptr_r);
    is_get = (cmd_r == CMD_GET);
    is_del = (cmd_r == CMD_DEL);
    is_ins = (cmd_r == CMD_HEAD) || (cmd_r == CMD_TAIL) || (cmd_r == CMD_AT);
    case (cmd_r)
      CMD_HEAD: ins_idx_e = '0;
      CMD_TAIL: ins_idx_e = cnt_e;
      default:  ins_idx_e = pos_e;
    endcase
    full      = (cnt_e == EW'(CAPACITY));
    get_ok    = is_get && (pos_e < cnt_e);
    del_ok    = is_del && (pos_e < cnt_e);
    ins_ok    = is_ins && !full && (ins_idx_e <= cnt_e);
    ins_shift = ins_ok && (ins_idx_e < cnt_e);
    del_shift = del_ok && ((pos_e + EW'(1)) < cnt_e);
    pos_addr  = pos_e[AW-1:0];
    ins_addr  = ins_idx_e[AW-1:0];
  end

  // Status toward the controller.
  always_comb begin
    stat.need_shift  = ins_shift || del_shift;
    stat.need_commit = ins_ok || del_ok;
    stat.shift_last  = is_ins ? (ptr_e == (ins_idx_e + EW'(1)))
                              : ((ptr_e + EW'(2)) == cnt_e);
    stat.out_free    = !out_valid_r || !out_stall;
  end

  // Memory port selection. Insert moves entries up from the top, delete
  // moves them down from the index.
  always_comb begin
    rd_en   = ctl.decide || ctl.shift_rd;
    rd_addr = pos_addr;
    if (ctl.shift_rd) begin
      rd_addr = is_ins ? (ptr_r - AW'(1)) : (ptr_r + AW'(1));
    end
    wr_en   = ctl.shift_wr || (ctl.commit && ins_ok);
    wr_addr = ctl.shift_wr ? ptr_r : ins_addr;
    wr_data = ctl.shift_wr ? rd_r : val_r;
  end

  // Count, pointer and output valid next values.
  always_comb begin
    count_nxt = count_r;
    if (ctl.commit && ins_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.commit && del_ok) begin
      count_nxt = count_r - CW'(1);
    end
    ptr_nxt = ptr_r;
    if (ctl.ptr_load) begin
      ptr_nxt = is_ins ? cnt_e[AW-1:0] : pos_addr;
    end else if (ctl.ptr_step) begin
      ptr_nxt = is_ins ? (ptr_r - AW'(1)) : (ptr_r + AW'(1));
    end
    if (ctl.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: latched command, pointer, status and result.
  always_ff @(posedge clk) begin
    if (ctl.latch_in) begin
      cmd_r <= in_cmd;
      pos_r <= in_position;
      val_r <= in_value;
    end
    ptr_r <= ptr_nxt;
    if (ctl.decide) begin
      ok_r <= get_ok || ins_ok || del_ok;
    end
    if (ctl.load_out) begin
      out_read_value_r  <= is_get ? (ok_r ? rd_r : RD_INVALID) : '0;
      out_accepted_r    <= ok_r;
      out_entry_count_r <= cnt_e[CNT_OUT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_accepted    = out_accepted_r;
  assign out_entry_count = out_entry_count_r;

endmodule

/* rtl/indexed_list_store.sv */
`timescale 1ns / 1ps
// A get or a rejected command is decided and its result then registered; an insert
// or delete also commits the count change, and each moved entry adds one memory read
// and one memory write (the shift read and shift write states). The next transaction
// is taken once the result is registered and the controller is idle, so one command
// is in progress at a time; the output register lets it be taken while that result
// still waits. Reset clears the entry count; store contents are kept.
// ----------------------------------------------------------------------------
// Indexed list store
// Ordered list of signed 32-bit entries with get, insert and delete at an index.
// ----------------------------------------------------------------------------
module indexed_list_store
  import ils_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic                     out_accepted,
  output logic [CNT_OUT_W-1:0]     out_entry_count
);

  ils_ctl_t  ctl;
  ils_stat_t stat;

  // Command sequencer.
  ils_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Entry store, count and output register.
  ils_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_cmd          (in_cmd),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_stall       (out_stall),
    .ctl             (ctl),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_accepted    (out_accepted),
    .out_entry_count (out_entry_count)
  );

endmodule

/* rtl/ils_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed list store checker
// Port-level checks on the list store, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "indexed_list_store_macros.svh"

module ils_checker
  import ils_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] out_read_value,
  input logic                     out_accepted,
  input logic [CNT_OUT_W-1:0]     out_entry_count
);

  logic [CNT_OUT_W-1:0] last_cnt_r;
  logic [CNT_OUT_W-1:0] cnt_step;
  logic                 in_seen;

  // Count reported by the previous result transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cnt_r <= '0;
    end else if (out_valid && !out_stall) begin
      last_cnt_r <= out_entry_count;
    end
  end

  assign cnt_step = out_entry_count - last_cnt_r;
  assign in_seen  = in_valid && !in_stall;

  // A stalled result holds its payload.
  `ILS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_read_value) && $stable(out_accepted) && $stable(out_entry_count), "stalled result changed")

  // Each command changes the count by at most one entry.
  `ILS_ASSERT_SAME(a_cnt_step, out_valid, cnt_step == '0 || cnt_step == CNT_OUT_W'(1) || cnt_step == '1, "entry count moved by more than one")

  // Only a successful get returns a value other than zero or minus one.
  `ILS_ASSERT_SAME(a_read_ok, out_valid && out_read_value != '0 && out_read_value != '1, out_accepted, "data returned without acceptance")

  // One command at a time: the input closes right after a transaction.
  `ILS_ASSERT_NEXT(a_one_cmd, in_seen, in_stall, "input open while a command is in progress")

endmodule

bind indexed_list_store ils_checker u_ils_checker (.*);
